[rtl/core/cds_pkg.sv]
`default_nettype none

package cds_pkg;

    localparam int YEAR_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int RESET_YEAR    = 2000;
    localparam int FALLBACK_YEAR = 2023;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] DAYS_28   = 5'd28;
    localparam logic [4:0] DAYS_29   = 5'd29;
    localparam logic [4:0] DAYS_30   = 5'd30;
    localparam logic [4:0] DAYS_31   = 5'd31;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load_set;
        logic load_other;
        logic step_en;
        logic step_back;
    } ctl_t;

    // Leap years are the years divisible by four, so only the two low bits matter.
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [1:0] year_lo);
        logic [4:0] len;
        len = DAYS_31;
        case (month) inside
            MONTH_FEB:
                len = (year_lo == 2'd0) ? DAYS_29 : DAYS_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV:
                len = DAYS_30;
            default:
                len = DAYS_31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/core/calendar_date_stepper.sv]
`default_nettype none

// Calendar date stepper. The block holds one date (month, day, year), reset to
// 1/1/2000, and takes one operation beat at a time: set (load a date, clamping
// a zero year to 2023, a bad month to January and the day to 1..month length),
// add days or subtract days. Every operation returns one result beat with the
// resulting date and a corrected flag that is set only when set had to repair a
// field. Leap years are the years divisible by four; the year wraps modulo
// 2^YEAR_BITS and cur_year shows its low 16 bits. Set, a zero day count and the
// unused operation code deliver the result in the cycle after the input beat is
// taken; add or subtract of N days walks one day per cycle through the single
// day-step unit and delivers the result once the walk is over. The next input
// beat is taken once the walk is over and the previous result beat has been
// taken (or is taken in the same cycle). Only the low COUNT_BITS bits of
// day_count are used.
module calendar_date_stepper #(
    parameter int YEAR_BITS  = cds_pkg::YEAR_BITS_DEF,
    parameter int COUNT_BITS = cds_pkg::COUNT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [3:0]  new_month,
    input  wire logic [4:0]  new_day,
    input  wire logic [15:0] new_year,
    input  wire logic [15:0] day_count,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [3:0]       cur_month,
    output logic [4:0]       cur_day,
    output logic [15:0]      cur_year,
    output logic             corrected
);

    cds_pkg::ctl_t ctl;

    // Held date; it doubles as the result register while a result beat waits.
    logic [3:0]           month_reg, month_next;
    logic [4:0]           day_reg, day_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic                 corrected_reg, corrected_next;

    logic [31:0]           new_year_ext;
    logic [31:0]           day_count_ext;
    logic [31:0]           year_out_ext;
    logic [COUNT_BITS-1:0] count_in;

    logic [YEAR_BITS-1:0] in_year;
    logic [YEAR_BITS-1:0] set_year;
    logic [3:0]           set_month;
    logic [4:0]           set_len;
    logic [4:0]           set_day;
    logic                 year_fix;
    logic                 month_fix;
    logic                 day_fix;

    logic [3:0]           step_month;
    logic [4:0]           step_day;
    logic [YEAR_BITS-1:0] step_year;

    assign new_year_ext  = 32'(new_year);
    assign day_count_ext = 32'(day_count);
    assign in_year       = new_year_ext[YEAR_BITS-1:0];
    assign count_in      = day_count_ext[COUNT_BITS-1:0];

    cds_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .op           (cds_pkg::op_t'(operation)),
        .count        (count_in),
        .ctl          (ctl)
    );

    cds_step_unit #(
        .YEAR_BITS (YEAR_BITS)
    ) u_step (
        .month      (month_reg),
        .day        (day_reg),
        .year       (year_reg),
        .back       (ctl.step_back),
        .next_month (step_month),
        .next_day   (step_day),
        .next_year  (step_year)
    );

    // Set path: repair the year first, then the month, then clamp the day
    // against the length of the repaired month.
    always_comb
    begin
        year_fix  = (in_year == '0);
        set_year  = year_fix ? YEAR_BITS'(cds_pkg::FALLBACK_YEAR) : in_year;
        month_fix = (new_month < cds_pkg::MONTH_JAN) || (new_month > cds_pkg::MONTH_DEC);
        set_month = month_fix ? cds_pkg::MONTH_JAN : new_month;
        set_len   = cds_pkg::month_length(set_month, set_year[1:0]);
        set_day   = new_day;
        day_fix   = 1'b0;
        if (new_day == 5'd0)
        begin
            set_day = cds_pkg::DAY_FIRST;
            day_fix = 1'b1;
        end
        else if (new_day > set_len)
        begin
            set_day = set_len;
            day_fix = 1'b1;
        end
    end

    always_comb
    begin
        month_next     = month_reg;
        day_next       = day_reg;
        year_next      = year_reg;
        corrected_next = corrected_reg;
        if (ctl.load_set)
        begin
            month_next     = set_month;
            day_next       = set_day;
            year_next      = set_year;
            corrected_next = year_fix || month_fix || day_fix;
        end
        else if (ctl.load_other)
        begin
            corrected_next = 1'b0;
        end
        else if (ctl.step_en)
        begin
            month_next = step_month;
            day_next   = step_day;
            year_next  = step_year;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            month_reg     <= cds_pkg::MONTH_JAN;
            day_reg       <= cds_pkg::DAY_FIRST;
            year_reg      <= YEAR_BITS'(cds_pkg::RESET_YEAR);
            corrected_reg <= 1'b0;
        end
        else
        begin
            month_reg     <= month_next;
            day_reg       <= day_next;
            year_reg      <= year_next;
            corrected_reg <= corrected_next;
        end
    end

    assign year_out_ext = 32'(year_reg);
    assign cur_month    = month_reg;
    assign cur_day      = day_reg;
    assign cur_year     = year_out_ext[15:0];
    assign corrected    = corrected_reg;

    // The held month always lies in 1..12 and the held day is never zero.
    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg >= cds_pkg::MONTH_JAN) && (month_reg <= cds_pkg::MONTH_DEC)
        && (day_reg != 5'd0))
        else $error("held date out of range");

    // No result beat may wait while the date is still being walked.
    a_walk_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step_en |-> !result_valid)
        else $error("result pending during day walk");

    // A set beat yields its result in the next cycle.
    a_set_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_set |=> result_valid)
        else $error("set did not produce a result");

    // Walking never reports a correction.
    a_walk_uncorrected: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step_en |-> !corrected_reg)
        else $error("corrected flag set during day walk");

endmodule

`default_nettype wire

[rtl/core/cds_step_unit.sv]
`default_nettype none

// Shared day stepper: advance or back off the date by one day.
module cds_step_unit #(
    parameter int YEAR_BITS = cds_pkg::YEAR_BITS_DEF
) (
    input  wire logic [3:0]           month,
    input  wire logic [4:0]           day,
    input  wire logic [YEAR_BITS-1:0] year,
    input  wire logic                 back,
    output logic      [3:0]           next_month,
    output logic      [4:0]           next_day,
    output logic      [YEAR_BITS-1:0] next_year
);

    logic [4:0] cur_len;
    logic [3:0] prev_month;
    logic [4:0] prev_len;

    assign cur_len    = cds_pkg::month_length(month, year[1:0]);
    assign prev_month = month - 4'd1;
    assign prev_len   = cds_pkg::month_length(prev_month, year[1:0]);

    always_comb
    begin
        next_month = month;
        next_day   = day;
        next_year  = year;
        if (!back)
        begin
            if (day < cur_len)
            begin
                next_day = day + 5'd1;
            end
            else if (month != cds_pkg::MONTH_DEC)
            begin
                next_day   = cds_pkg::DAY_FIRST;
                next_month = month + 4'd1;
            end
            else
            begin
                next_day   = cds_pkg::DAY_FIRST;
                next_month = cds_pkg::MONTH_JAN;
                next_year  = year + YEAR_BITS'(1);
            end
        end
        else
        begin
            if (day > cds_pkg::DAY_FIRST)
            begin
                next_day = day - 5'd1;
            end
            else if (month <= cds_pkg::MONTH_JAN)
            begin
                next_month = cds_pkg::MONTH_DEC;
                next_day   = cds_pkg::DAYS_31;
                next_year  = year - YEAR_BITS'(1);
            end
            else
            begin
                next_month = prev_month;
                next_day   = prev_len;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/cds_ctrl.sv]
`default_nettype none

// Sequencer: take a beat, count down the day walk, hold the result beat.
module cds_ctrl #(
    parameter int COUNT_BITS = cds_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    input  wire cds_pkg::op_t          op,
    input  wire logic [COUNT_BITS-1:0] count,
    output cds_pkg::ctl_t              ctl
);

    cds_pkg::state_t       state_reg, state_next;
    logic [COUNT_BITS-1:0] steps_left_reg, steps_left_next;
    logic                  back_reg, back_next;
    logic                  result_valid_reg, result_valid_next;

    logic accept;
    logic is_walk_op;
    logic start_walk;
    logic last_step;

    assign accept     = item_valid && !item_stall;
    assign is_walk_op = (op == cds_pkg::OP_ADD) || (op == cds_pkg::OP_SUB);
    assign start_walk = accept && is_walk_op && (count != '0);
    assign last_step  = (state_reg == cds_pkg::ST_WALK)
                        && (steps_left_reg == COUNT_BITS'(1));

    always_comb
    begin
        state_next        = state_reg;
        steps_left_next   = steps_left_reg;
        back_next         = back_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            cds_pkg::ST_IDLE:
            begin
                if (start_walk)
                begin
                    state_next      = cds_pkg::ST_WALK;
                    steps_left_next = count;
                    back_next       = (op == cds_pkg::OP_SUB);
                end
                else if (accept)
                begin
                    result_valid_next = 1'b1;
                end
            end
            cds_pkg::ST_WALK:
            begin
                steps_left_next = steps_left_reg - COUNT_BITS'(1);
                if (last_step)
                begin
                    state_next        = cds_pkg::ST_IDLE;
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = cds_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall     = (state_reg != cds_pkg::ST_IDLE)
                         || (result_valid_reg && result_stall);
        result_valid   = result_valid_reg;
        ctl.load_set   = accept && (op == cds_pkg::OP_SET);
        ctl.load_other = accept && (op != cds_pkg::OP_SET);
        ctl.step_en    = (state_reg == cds_pkg::ST_WALK);
        ctl.step_back  = back_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cds_pkg::ST_IDLE;
            steps_left_reg   <= '0;
            back_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            steps_left_reg   <= steps_left_next;
            back_reg         <= back_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

`default_nettype wire
